// File: rtl/core/uart_keyword_detector_unit_macros.svh
// Assertion macros for the uart keyword detector.
// Used by uart_keyword_detector_unit; expects clk and arst_n in scope.
`ifndef UART_KEYWORD_DETECTOR_UNIT_MACROS_SVH
`define UART_KEYWORD_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define UKD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UKD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ukd_pkg.sv
// Shared types and constants for the uart keyword detector.
// No dependencies.
package ukd_pkg;

	typedef enum logic [0:0] {
		OP_BYTE  = 1'b0,
		OP_CHECK = 1'b1
	} opcode_t;

	typedef enum logic [0:0] {
		EV_PONG = 1'b0,
		EV_ACK  = 1'b1
	} event_t;

	localparam int PONG_LEN = 4;
	localparam int ACK_LEN  = 3;

	// index 0 is the first character
	localparam logic [PONG_LEN-1:0][7:0] KW_PONG = {8'h67, 8'h6e, 8'h6f, 8'h70};
	localparam logic [ACK_LEN-1:0][7:0]  KW_ACK  = {8'h6b, 8'h63, 8'h61};

	typedef struct packed {
		logic pong;
		logic ack;
	} match_t;

	typedef struct packed {
		logic take_byte;
		logic clear_pos;
	} win_ctl_t;

endpackage

// File: rtl/core/uart_keyword_detector_unit.sv
// Top level of the uart keyword detector: input register, window, search, result register.
// Depends on ukd_pkg, ukd_window, ukd_match and uart_keyword_detector_unit_macros.svh.
//
// Each request is a received byte or a check. A request is taken into an input
// register; a byte is applied to the window in the following cycle, and a check's
// result is loaded into the output register when the check leaves the input
// register, which a held output register can delay. One request per cycle is
// sustained; in_stall rises only while a check that has a result to post waits
// on a held output register. Checks with an empty window and received bytes give
// no result. The search over the window is combinational, by parallel compares.
module uart_keyword_detector_unit #(
	parameter int WINDOW_BYTES = 16,
	parameter int SHIFT_BYTES  = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ukd_pkg::opcode_t     opcode,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 matched,
	output ukd_pkg::event_t      event_code
);
	import ukd_pkg::*;

`include "uart_keyword_detector_unit_macros.svh"

	logic                         valid_s1;
	opcode_t                      opcode_s1;
	logic [7:0]                   rx_byte_s1;
	logic                         out_valid_q;
	logic                         matched_q;
	event_t                       event_code_q;
	logic [WINDOW_BYTES-1:0][7:0] window;
	logic                         pos_zero;
	match_t                       hits;
	win_ctl_t                     ctl;
	logic                         produces;
	logic                         advance;
	logic                         fire;

	assign produces = valid_s1 && (opcode_s1 == OP_CHECK) && !pos_zero;
	assign advance  = !produces || !out_valid_q || !out_stall;
	assign fire     = produces && advance;
	assign in_stall = valid_s1 && !advance;

	assign ctl.take_byte = valid_s1 && (opcode_s1 == OP_BYTE);
	assign ctl.clear_pos = fire && (hits.pong || hits.ack);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			opcode_s1  <= opcode;
			rx_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			matched_q    <= hits.pong || hits.ack;
			event_code_q <= (!hits.pong && hits.ack) ? EV_ACK : EV_PONG;
		end
	end

	ukd_window #(
		.WINDOW_BYTES(WINDOW_BYTES),
		.SHIFT_BYTES (SHIFT_BYTES)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rx_byte (rx_byte_s1),
		.window  (window),
		.pos_zero(pos_zero)
	);

	ukd_match #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_match (
		.window(window),
		.hits  (hits)
	);

	assign out_valid  = out_valid_q;
	assign matched    = matched_q;
	assign event_code = event_code_q;

	`UKD_ASSERT_IMPL(a_stall_cause, in_stall, valid_s1 && out_valid_q && out_stall, "stall without a held result")
	`UKD_ASSERT_NEXT(a_hit_clears_pos, ctl.clear_pos, pos_zero, "position not cleared after match")
	`UKD_ASSERT_IMPL(a_ack_implies_match, out_valid_q && (event_code_q == EV_ACK), matched_q, "ack code without match")

endmodule

// File: rtl/core/ukd_match.sv
// Parallel keyword search over the byte window.
// Depends on ukd_pkg.
module ukd_match #(
	parameter int WINDOW_BYTES = 16
) (
	input  logic [WINDOW_BYTES-1:0][7:0] window,
	output ukd_pkg::match_t              hits
);
	import ukd_pkg::*;

	logic [WINDOW_BYTES-PONG_LEN:0] pong_at;
	logic [WINDOW_BYTES-ACK_LEN:0]  ack_at;

	always_comb begin
		for (int s = 0; s <= WINDOW_BYTES - PONG_LEN; s++) begin
			pong_at[s] = 1'b1;
			for (int k = 0; k < PONG_LEN; k++) begin
				if (window[s + k] != KW_PONG[k]) begin
					pong_at[s] = 1'b0;
				end
			end
		end
		for (int s = 0; s <= WINDOW_BYTES - ACK_LEN; s++) begin
			ack_at[s] = 1'b1;
			for (int k = 0; k < ACK_LEN; k++) begin
				if (window[s + k] != KW_ACK[k]) begin
					ack_at[s] = 1'b0;
				end
			end
		end
	end

	assign hits.pong = |pong_at;
	assign hits.ack  = |ack_at;

endmodule

// File: rtl/core/ukd_window.sv
// Receive window and write position, with clear-on-start and slide-down on full.
// Depends on ukd_pkg.
module ukd_window #(
	parameter int WINDOW_BYTES = 16,
	parameter int SHIFT_BYTES  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ukd_pkg::win_ctl_t            ctl,
	input  logic [7:0]                   rx_byte,
	output logic [WINDOW_BYTES-1:0][7:0] window,
	output logic                         pos_zero
);
	import ukd_pkg::*;

	localparam int POS_W = $clog2(WINDOW_BYTES);
	localparam logic [POS_W:0] POS_FULL = (POS_W + 1)'(WINDOW_BYTES);
	localparam logic [POS_W-1:0] POS_AFTER =
		(SHIFT_BYTES < WINDOW_BYTES) ? POS_W'(WINDOW_BYTES - SHIFT_BYTES) : '0;

	logic [WINDOW_BYTES-1:0][7:0] window_q;
	logic [WINDOW_BYTES-1:0][7:0] base;
	logic [WINDOW_BYTES-1:0][7:0] win_nxt;
	logic [POS_W-1:0]             pos_q;
	logic [POS_W-1:0]             pos_nxt;
	logic [POS_W:0]               pos_inc;

	always_comb begin
		base = (pos_q == '0) ? '0 : window_q;
		for (int i = 0; i < WINDOW_BYTES; i++) begin
			if (pos_q == POS_W'(i)) begin
				base[i] = rx_byte;
			end
		end
		pos_inc = {1'b0, pos_q} + 1'b1;
		win_nxt = base;
		pos_nxt = pos_inc[POS_W-1:0];
		if (pos_inc == POS_FULL) begin
			for (int j = 0; j < WINDOW_BYTES - SHIFT_BYTES; j++) begin
				win_nxt[j] = base[j + SHIFT_BYTES];
			end
			win_nxt[WINDOW_BYTES-1] = '0;
			pos_nxt = POS_AFTER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			pos_q    <= '0;
		end else if (ctl.take_byte) begin
			window_q <= win_nxt;
			pos_q    <= pos_nxt;
		end else if (ctl.clear_pos) begin
			pos_q <= '0;
		end
	end

	assign window   = window_q;
	assign pos_zero = (pos_q == '0);

endmodule
